>>> hw/rtl/obtmf_pkg.sv
package obtmf_pkg;

    localparam int MAX_BAR_LEN_DEF   = 8;
    localparam int MAX_WIDTH_DEF     = 1024;
    localparam int NUM_TEMPLATES_DEF = 32;
    localparam int MAX_HEIGHT        = 1024;
    localparam int CFG_W             = 11;
    localparam int SUM_W             = 34;

    localparam logic [7:0] SAT_VAL = 8'd255;

    typedef enum logic [1:0] {
        REQ_PIXEL = 2'd0,
        REQ_COEF  = 2'd1,
        REQ_COUNT = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    localparam logic [1:0] CFG_BAR    = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PIX,
        ST_MAC,
        ST_MAC_END,
        ST_DIV_START,
        ST_DIV,
        ST_REDUCE,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic take_in;
        logic do_load;
        logic do_pix;
        logic mac_clear;
        logic mac_step;
        logic div_start;
        logic div_step;
        logic reduce;
        logic next_tmpl;
        logic out_load;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_pixel;
        logic is_border;
        logic win_last;
        logic tmpl_last;
        logic div_done;
        logic div_bypass;
    } dp_stat_t;

endpackage

>>> hw/rtl/obtmf_ctrl.sv
module obtmf_ctrl
    import obtmf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     out_busy,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (stat.is_pixel)
                begin
                    state_next = ST_PIX;
                end
                else
                begin
                    cmd.do_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_PIX:
            begin
                // store the pixel, then walk windows unless on the border
                cmd.do_pix    = 1'b1;
                cmd.mac_clear = 1'b1;
                state_next    = stat.is_border ? ST_OUT : ST_MAC;
            end
            ST_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (stat.win_last)
                begin
                    state_next = ST_MAC_END;
                end
            end
            ST_MAC_END:
            begin
                // let the last product land in the accumulator
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = stat.div_bypass ? ST_REDUCE : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                if (stat.tmpl_last)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.next_tmpl = 1'b1;
                    cmd.mac_clear = 1'b1;
                    state_next    = ST_MAC;
                end
            end
            ST_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> state_reg == ST_IDLE)
        else $error("output load did not return to idle");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_in |=> state_reg == ST_LOAD)
        else $error("accepted beat not loaded");
`endif

endmodule

>>> hw/rtl/obtmf_dp.sv
module obtmf_dp
    import obtmf_pkg::*;
#(
    parameter int MAX_BAR_LEN   = MAX_BAR_LEN_DEF,
    parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
    parameter int NUM_TEMPLATES = NUM_TEMPLATES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    output dp_stat_t         stat,
    input  logic [3:0]       win_len,
    input  logic [CFG_W-1:0] image_width,
    input  logic [CFG_W-1:0] image_height,
    input  logic [1:0]       req_type,
    input  logic [7:0]       pixel,
    input  logic [4:0]       tmpl_index,
    input  logic [5:0]       coef_index,
    input  logic signed [15:0] coef_value,
    input  logic [6:0]       count_value,
    output logic [7:0]       res_value,
    output logic             res_last
);

    localparam int AREA = MAX_BAR_LEN * MAX_BAR_LEN;
    localparam int LW   = $clog2(MAX_BAR_LEN + 1);
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int TW   = (NUM_TEMPLATES > 1) ? $clog2(NUM_TEMPLATES) : 1;
    localparam int CW   = $clog2(AREA);
    localparam int TC   = NUM_TEMPLATES * AREA;
    localparam int TCW  = $clog2(TC);
    localparam int RSW  = $clog2(MAX_BAR_LEN * MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);

    // memories
    logic [7:0]        row_mem  [MAX_BAR_LEN * MAX_WIDTH];
    logic signed [15:0] tmpl_mem [TC];
    logic [6:0]        cnt_mem  [NUM_TEMPLATES];

    // captured request
    logic [1:0]  req_reg;
    logic [7:0]  pix_reg;
    logic [4:0]  ti_reg;
    logic [5:0]  ci_reg;
    logic [15:0] cv_reg;
    logic [6:0]  cn_reg;

    // counters and limits
    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic [LW-1:0] len;
    logic [CFG_W-1:0] w_eff, h_eff;

    // window walk
    logic [TW-1:0] t_reg;
    logic [LW-1:0] dr_reg, dc_reg;
    logic [CW-1:0] cidx_reg;
    logic          rd_v_reg;
    logic [7:0]    p_rd_reg;
    logic signed [15:0] c_rd_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic [6:0]    cnt_rd_reg;

    // divider
    logic [SUM_W-1:0] rem_reg;
    logic [8:0]       q_reg;
    logic [3:0]       dbit_reg;
    logic [7:0]       best_reg;
    logic             edge_x, edge_y;

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            req_reg <= req_type;
            pix_reg <= pixel;
            ti_reg  <= tmpl_index;
            ci_reg  <= coef_index;
            cv_reg  <= coef_value;
            cn_reg  <= count_value;
        end
    end

    // clamp configuration
    always_comb
    begin
        if (win_len == '0)
            len = LW'(1);
        else if (32'(win_len) > MAX_BAR_LEN)
            len = LW'(MAX_BAR_LEN);
        else
            len = LW'(win_len);
        if (image_width == '0)
            w_eff = CFG_W'(1);
        else if (32'(image_width) > MAX_WIDTH)
            w_eff = CFG_W'(MAX_WIDTH);
        else
            w_eff = image_width;
        if (image_height == '0)
            h_eff = CFG_W'(1);
        else if (32'(image_height) > MAX_HEIGHT)
            h_eff = CFG_W'(MAX_HEIGHT);
        else
            h_eff = image_height;
    end

    assign edge_x = 32'(x_reg) >= 32'(w_eff) - 1;
    assign edge_y = 32'(y_reg) >= 32'(h_eff) - 1;

    assign stat.is_pixel  = (req_reg == REQ_PIXEL);
    assign stat.is_border = (32'(y_reg) < 32'(len) - 1) || (32'(x_reg) < 32'(len) - 1);
    assign stat.win_last  = (dr_reg == len - LW'(1)) && (dc_reg == len - LW'(1));
    assign stat.tmpl_last = (32'(t_reg) == NUM_TEMPLATES - 1);

    // loads
    always_ff @(posedge clk)
    begin
        if (cmd.do_load && req_reg == REQ_COEF && 32'(ti_reg) < NUM_TEMPLATES
            && 32'(ci_reg) < AREA)
        begin
            tmpl_mem[TCW'(32'(ti_reg) * AREA + 32'(ci_reg))] <= cv_reg;
        end
        if (cmd.do_load && req_reg == REQ_COUNT && 32'(ti_reg) < NUM_TEMPLATES)
        begin
            cnt_mem[TW'(ti_reg)] <= cn_reg;
        end
    end

    // store pixel into the row ring
    always_ff @(posedge clk)
    begin
        if (cmd.do_pix)
        begin
            row_mem[RSW'(32'(y_reg % MAX_BAR_LEN) * MAX_WIDTH + 32'(x_reg))] <= pix_reg;
        end
    end

    // window memory reads, one tap per cycle
    always_ff @(posedge clk)
    begin
        p_rd_reg   <= row_mem[RSW'((32'(y_reg) - 32'(len) + 1 + 32'(dr_reg)) % MAX_BAR_LEN
                      * MAX_WIDTH + 32'(x_reg) - 32'(len) + 1 + 32'(dc_reg))];
        c_rd_reg   <= tmpl_mem[TCW'(32'(t_reg) * AREA + 32'(cidx_reg))];
        cnt_rd_reg <= cnt_mem[TW'(t_reg)];
    end

    // position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
        end
        else if (cmd.out_load && req_reg == REQ_PIXEL)
        begin
            if (edge_x)
            begin
                x_reg <= '0;
                y_reg <= edge_y ? '0 : y_reg + YW'(1);
            end
            else
            begin
                x_reg <= x_reg + XW'(1);
            end
        end
    end

    // walk and accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg    <= '0;
            dr_reg   <= '0;
            dc_reg   <= '0;
            cidx_reg <= '0;
            rd_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= cmd.mac_step;
            if (cmd.do_pix)
            begin
                t_reg <= '0;
            end
            else if (cmd.next_tmpl)
            begin
                t_reg <= t_reg + TW'(1);
            end
            if (cmd.mac_clear)
            begin
                dr_reg   <= '0;
                dc_reg   <= '0;
                cidx_reg <= '0;
            end
            else if (cmd.mac_step && !stat.win_last)
            begin
                cidx_reg <= cidx_reg + CW'(1);
                if (dc_reg == len - LW'(1))
                begin
                    dc_reg <= '0;
                    dr_reg <= dr_reg + LW'(1);
                end
                else
                begin
                    dc_reg <= dc_reg + LW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_clear)
        begin
            acc_reg <= '0;
        end
        else if (rd_v_reg)
        begin
            acc_reg <= acc_reg + SUM_W'($signed({1'b0, p_rd_reg}) * c_rd_reg);
        end
    end

    // restoring divide of |acc| by 256*count, 9 quotient bits
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] dsh;
    assign mag = acc_reg[SUM_W-1] ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);
    assign dsh = SUM_W'({cnt_rd_reg, 8'd0}) << dbit_reg;
    assign stat.div_bypass = (cnt_rd_reg == '0);
    assign stat.div_done   = (dbit_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            // quotient over 511 saturates anyway, so cap the magnitude
            rem_reg  <= (mag >= (SUM_W'({cnt_rd_reg, 8'd0}) << 9)) ?
                        (SUM_W'({cnt_rd_reg, 8'd0}) << 9) - SUM_W'(1) : mag;
            q_reg    <= stat.div_bypass ? 9'd255 : '0;
            dbit_reg <= 4'd8;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= dsh)
            begin
                rem_reg <= rem_reg - dsh;
                q_reg   <= q_reg | (9'd1 << dbit_reg);
            end
            if (dbit_reg != '0)
            begin
                dbit_reg <= dbit_reg - 4'd1;
            end
        end
    end

    // running maximum, reset to zero by a zero response
    logic [7:0] q_sat;
    assign q_sat = (q_reg > 9'd255) ? SAT_VAL : q_reg[7:0];

    always_ff @(posedge clk)
    begin
        if (cmd.do_pix)
        begin
            best_reg <= '0;
        end
        else if (cmd.reduce)
        begin
            if (q_sat == '0)
                best_reg <= '0;
            else if (q_sat > best_reg)
                best_reg <= q_sat;
        end
    end

    assign res_value = SAT_VAL - best_reg;
    assign res_last  = edge_x && edge_y;

`ifndef ASSERT_OFF
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step && !stat.div_done |=> cmd.div_step || $past(dbit_reg) == 4'd1)
        else $error("divider left early");
    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(x_reg) < MAX_WIDTH)
        else $error("column out of range");
    a_reduce_dp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.reduce |=> best_reg == '0 || best_reg >= $past(best_reg))
        else $error("max dropped without zero response");
`endif

endmodule

>>> hw/rtl/oriented_bar_template_max_filter.sv
// Oriented bar template max filter. Accepts pixels and template/count loads
// one beat at a time; a load gives no result. The time a pixel beat takes is
// set by the single multiply-accumulate that walks each template window and
// a 9-step restoring divider per template; a template with a zero count skips
// the divider. Border pixels skip the window walk. A stalled result holds the
// next beat until the result register is free.
// Template, count and row stores are undefined until written.
module oriented_bar_template_max_filter
    import obtmf_pkg::*;
#(
    parameter int MAX_BAR_LEN   = MAX_BAR_LEN_DEF,
    parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
    parameter int NUM_TEMPLATES = NUM_TEMPLATES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       req_type,
    input  logic [7:0]       pixel,
    input  logic [4:0]       tmpl_index,
    input  logic [5:0]       coef_index,
    input  logic signed [15:0] coef_value,
    input  logic [6:0]       count_value,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       line_value,
    output logic             frame_last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [3:0]       bar_reg;
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [7:0]       res_value;
    logic             res_last;
    logic             out_busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_reg    <= 4'd3;
            width_reg  <= CFG_W'(640);
            height_reg <= CFG_W'(480);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BAR:    bar_reg    <= cfg_data[3:0];
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    bar_reg    <= bar_reg;
            endcase
        end
    end

    obtmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_busy (out_busy),
        .stat     (stat),
        .cmd      (cmd)
    );

    obtmf_dp #(
        .MAX_BAR_LEN   (MAX_BAR_LEN),
        .MAX_WIDTH     (MAX_WIDTH),
        .NUM_TEMPLATES (NUM_TEMPLATES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .win_len      (bar_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .req_type     (req_type),
        .pixel        (pixel),
        .tmpl_index   (tmpl_index),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .count_value  (count_value),
        .res_value    (res_value),
        .res_last     (res_last)
    );

    // result register
    logic out_valid_reg;
    logic [7:0] line_reg;
    logic last_reg;
    assign out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            line_reg <= res_value;
            last_reg <= res_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_value = line_reg;
    assign frame_last = last_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten");
    a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result not shown");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_in |-> in_valid)
        else $error("beat taken without valid");
`endif

endmodule

>>> bench/oriented_bar_template_max_filter_test.sv
`timescale 1ns / 100ps

module oriented_bar_template_max_filter_test;
    import obtmf_pkg::*;

    typedef struct {
        req_t        kind;
        logic [7:0]  pix;
        logic [4:0]  tmpl;
        logic [5:0]  cidx;
        logic [15:0] cval;
        logic [6:0]  cnt;
    } beat_t;

    typedef struct {
        logic [7:0] line;
        logic       last;
    } line_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_BAR;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] req_type = REQ_PIXEL;
    logic [7:0] pixel = '0;
    logic [4:0] tmpl_index = '0;
    logic [5:0] coef_index = '0;
    logic signed [15:0] coef_value = '0;
    logic [6:0] count_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] line_value;
    logic frame_last;

    oriented_bar_template_max_filter u_top (.*);

    // pending beats, expected line values, error tally
    beat_t        pending_beats[$];
    line_result_t line_expect_q[$];
    int           err_count = 0;
    int           beat_total = 0;
    logic         took = 1'b0;

    // shadow state of the filter
    logic [7:0]         row_mem[8*1024];
    logic signed [15:0] coef_mem[2048];
    logic [6:0]         count_mem[32];
    int unsigned        col_ctr = 0;
    int unsigned        row_ctr = 0;
    int unsigned        bar_reg = 3;
    int unsigned        width_reg = 640;
    int unsigned        height_reg = 480;

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // best template response over the window ending at (x, y)
    function automatic int unsigned max_response(int unsigned l, int unsigned x,
                                                 int unsigned y);
        int unsigned best;
        longint      acc;
        longint      mag;
        longint      q;
        int unsigned ry;
        int unsigned cx;
        best = 0;
        for (int t = 0; t < 32; t++)
        begin
            acc = 0;
            for (int unsigned dr = 0; dr < l; dr++)
            begin
                ry = (y - (l - 1) + dr) % 8;
                for (int unsigned dc = 0; dc < l; dc++)
                begin
                    cx = x - (l - 1) + dc;
                    acc += longint'(row_mem[ry*1024 + cx])
                         * longint'(coef_mem[t*64 + dc + dr*l]);
                end
            end
            mag = (acc < 0) ? -acc : acc;
            if (count_mem[t] == 0)
                q = 255;
            else
            begin
                q = mag / (256 * longint'(count_mem[t]));
                if (q > 255)
                    q = 255;
            end
            if (q == 0)
                best = 0;
            else if (q > best)
                best = 32'(q);
        end
        return best;
    endfunction

    // advance the shadow state by one beat and queue any line value
    function automatic void predict_beat(beat_t b);
        int unsigned  l;
        int unsigned  w;
        int unsigned  h;
        int unsigned  x;
        int unsigned  y;
        int unsigned  best;
        line_result_t r;
        case (b.kind)
            REQ_COEF:  coef_mem[b.tmpl*64 + b.cidx] = b.cval;
            REQ_COUNT: count_mem[b.tmpl] = b.cnt;
            REQ_PIXEL:
            begin
                l = clamp_reg(bar_reg, 8);
                w = clamp_reg(width_reg, 1024);
                h = clamp_reg(height_reg, 1024);
                x = col_ctr % 1024;
                y = row_ctr % 1024;
                row_mem[(y % 8)*1024 + x] = b.pix;
                if (y < l - 1 || x < l - 1)
                    best = 0;
                else
                    best = max_response(l, x, y);
                r.line = 8'(255 - best);
                r.last = (x >= w - 1) && (y >= h - 1);
                if (x >= w - 1)
                begin
                    col_ctr = 0;
                    row_ctr = (y >= h - 1) ? 0 : y + 1;
                end
                else
                begin
                    col_ctr = x + 1;
                    row_ctr = y;
                end
                line_expect_q.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // accept beats, predict, and check line values
    always @(posedge clk)
    begin
        line_result_t e;
        took <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            beat_t b;
            b.kind = req_t'(req_type);
            b.pix  = pixel;
            b.tmpl = tmpl_index;
            b.cidx = coef_index;
            b.cval = coef_value;
            b.cnt  = count_value;
            predict_beat(b);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (line_expect_q.size() == 0)
            begin
                $error("unexpected result: line_value %0d frame_last %0b",
                       line_value, frame_last);
                err_count++;
            end
            else
            begin
                e = line_expect_q.pop_front();
                if (line_value !== e.line)
                begin
                    $error("line_value: expected %0d, got %0d", e.line, line_value);
                    err_count++;
                end
                if (frame_last !== e.last)
                begin
                    $error("frame_last: expected %0b, got %0b", e.last, frame_last);
                    err_count++;
                end
            end
        end
    end

    // send beats in bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge clk)
    begin
        beat_t b;
        if (rst_n && (!in_valid || took))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                b = pending_beats.pop_front();
                req_type    <= b.kind;
                pixel       <= b.pix;
                tmpl_index  <= b.tmpl;
                coef_index  <= b.cidx;
                coef_value  <= b.cval;
                count_value <= b.cnt;
                in_valid    <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // stall the result side on a rotating pattern
    int unsigned stall_cyc = 0;
    int unsigned stall_mode = 0;
    logic [31:0] stall_pat = '1;
    always @(negedge clk)
    begin
        if (stall_cyc % 64 == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_pat = $urandom;
        end
        out_ready <= (stall_mode == 0) ? 1'b1 : stall_pat[stall_cyc % 32];
        stall_cyc++;
    end

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'($signed($urandom_range(0, 128)) - 64);
            2: return 16'($signed($urandom_range(0, 2048)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_beat(req_t k, logic [7:0] p, logic [4:0] t, logic [5:0] ci,
                             logic [15:0] cv, logic [6:0] cn);
        beat_t b;
        b.kind = k;
        b.pix = p;
        b.tmpl = t;
        b.cidx = ci;
        b.cval = cv;
        b.cnt = cn;
        pending_beats.push_back(b);
        if (k != REQ_NONE)
            beat_total++;
    endtask

    task automatic push_pixel(logic [7:0] p);
        push_beat(REQ_PIXEL, p, 5'($urandom), 6'($urandom), 16'($urandom), 7'($urandom));
    endtask

    task automatic push_random_load();
        if ($urandom_range(0, 3) == 0)
            push_beat(REQ_COUNT, 8'($urandom), 5'($urandom), 6'($urandom), 16'($urandom),
                      7'($urandom_range(0, 64)));
        else
            push_beat(REQ_COEF, 8'($urandom), 5'($urandom), 6'($urandom), rand_coef(),
                      7'($urandom));
    endtask

    // wait for the filter to go idle, then write all three registers
    task automatic set_config(int unsigned l, int unsigned w, int unsigned h);
        while (pending_beats.size() != 0 || in_valid || line_expect_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_BAR;
        cfg_data <= CFG_W'(l);
        @(negedge clk);
        cfg_index <= CFG_WIDTH;
        cfg_data <= CFG_W'(w);
        @(negedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data <= CFG_W'(h);
        @(negedge clk);
        cfg_we <= 1'b0;
        bar_reg = l & 4'hF;
        width_reg = w & 11'h7FF;
        height_reg = h & 11'h7FF;
    endtask

    initial
    begin
        int unsigned l;
        int unsigned w;
        int unsigned h;
        int unsigned n_pix;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill every count and the taps of a window up to two pixels wide
        for (int t = 0; t < 32; t++)
        begin
            for (int c = 0; c < 4; c++)
                push_beat(REQ_COEF, 8'd0, 5'(t), 6'(c), rand_coef(), 7'd0);
            push_beat(REQ_COUNT, 8'd0, 5'(t), 6'd0, 16'd0, 7'($urandom_range(0, 64)));
        end

        // directed: field extremes, zero count, unknown request, border pixels
        push_beat(REQ_COEF, 8'hFF, 5'd31, 6'd63, 16'h8000, 7'h7F);
        push_beat(REQ_COEF, 8'h00, 5'd0, 6'd0, 16'h7FFF, 7'h00);
        push_beat(REQ_COUNT, 8'h00, 5'd31, 6'd0, 16'd0, 7'd64);
        push_beat(REQ_COUNT, 8'h00, 5'd1, 6'd0, 16'd0, 7'd0);
        push_beat(REQ_NONE, 8'hFF, 5'd31, 6'd63, 16'hFFFF, 7'h7F);
        push_pixel(8'd0);
        push_pixel(8'd255);

        // clamped bar length, width and height at their top
        set_config(15, 11'h7FF, 11'h7FF);
        push_pixel(8'd255);
        push_pixel(8'd0);
        push_pixel(8'd128);
        // zero values act as one and wrap the counters home
        set_config(0, 0, 0);
        push_pixel(8'd255);

        // small frame with saturating pixels
        set_config(2, 3, 3);
        repeat (9) push_pixel(8'd255);

        // random phases of whole frames with loads mixed in
        while (beat_total < 290)
        begin
            case ($urandom_range(0, 7))
                0: l = $urandom_range(3, 8);
                1: l = 15;
                default: l = $urandom_range(1, 2);
            endcase
            h = $urandom_range(1, 6);
            // wide windows only see rows too short to hold them: all border
            if (l > 2)
                w = $urandom_range(1, (l > 8) ? 7 : l - 1);
            else
                w = $urandom_range(1, 10);
            set_config(l, w, h);
            n_pix = w * h * $urandom_range(1, 2);
            for (int unsigned i = 0; i < n_pix; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                    push_random_load();
                if ($urandom_range(0, 24) == 0)
                    push_beat(REQ_NONE, 8'($urandom), 5'($urandom), 6'($urandom),
                              16'($urandom), 7'($urandom));
                push_pixel(8'($urandom));
            end
        end

        while (pending_beats.size() != 0 || in_valid || line_expect_q.size() != 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
        if (err_count == 0 && line_expect_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
